>>> hdl/nsrc_pkg.sv
package nsrc_pkg;

  // Width of the frame counters
  localparam int COUNT_BITS = 24;
  localparam int POS_BITS   = 32;
  localparam int LIMIT_BITS = 24;
  localparam int STEP_BITS  = 11;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;
  // Common width for comparing counters against the limit and frame positions
  localparam int CMP_W = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
  localparam int RUN_BITS = 3;   // outputs per input frame, up to eight

  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDE     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP     = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT    = 2'd3;

  localparam logic [1:0] CHANNELS_STEREO = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;     // capture a source frame
    logic emit;     // load the output register and advance the counters
    logic last;     // this output closes the run
    logic finish;   // source frame done
  } nsrc_cmd_t;

  typedef struct packed {
    logic emit_ok;   // another output maps to the current frame
    logic more_next; // one more would follow after the next emit
    logic out_free;  // output register can take a value this cycle
  } nsrc_status_t;

endpackage

>>> hdl/nsrc_ctrl.sv
module nsrc_ctrl
  import nsrc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  nsrc_status_t status,
  output nsrc_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic [RUN_BITS-1:0] run_r, run_nxt;
  logic run_full;

  assign run_full = (run_r == {RUN_BITS{1'b1}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      run_r   <= '0;
    end else begin
      state_r <= state_nxt;
      run_r   <= run_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    run_nxt    = run_r;
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          run_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!status.emit_ok) begin
          // nothing maps to this frame
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = !status.more_next || run_full;
          run_nxt  = run_r + 1'b1;
          if (cmd.last) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> hdl/nsrc_datapath.sv
module nsrc_datapath
  import nsrc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic [2*SAMPLE_BITS-1:0] in_tdata,
  input  nsrc_cmd_t                cmd,
  output nsrc_status_t             status,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [2*SAMPLE_BITS-1:0] out_tdata,
  output logic                     out_tlast
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [1:0]            channels_r;
  logic                  wide_r;
  logic [STEP_BITS-1:0]  step_r;
  logic [LIMIT_BITS-1:0] limit_r;

  logic [COUNT_BITS-1:0] src_r;
  logic [COUNT_BITS-1:0] emitted_r;
  logic [POS_BITS-1:0]   pos_r;

  logic [SAMPLE_BITS-1:0] first_r, second_r;
  logic [SAMPLE_BITS-1:0] first_w, second_w;

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_first_r, out_second_r;
  logic                   out_last_r;

  logic [POS_BITS:0]     pos_sum;
  logic [POS_BITS-1:0]   pos_sat;
  logic [COUNT_BITS-1:0] emitted_inc;
  logic [CMP_W-1:0]      limit_x, src_x;

  function automatic logic [SAMPLE_BITS-1:0] widen(input logic wide,
                                                   input logic [SAMPLE_BITS-1:0] raw);
    if (wide) begin
      return raw;
    end
    return {raw[7:0] ^ 8'h80, 8'h00};
  endfunction

  assign first_w  = widen(wide_r, in_tdata[SAMPLE_BITS-1:0]);
  assign second_w = (channels_r == CHANNELS_STEREO) ?
                    widen(wide_r, in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]) : '0;

  // Saturating step of the output position
  assign pos_sum     = {1'b0, pos_r} + (POS_BITS+1)'(step_r);
  assign pos_sat     = pos_sum[POS_BITS] ? {POS_BITS{1'b1}} : pos_sum[POS_BITS-1:0];
  assign emitted_inc = emitted_r + 1'b1;
  assign limit_x     = CMP_W'(limit_r);
  assign src_x       = CMP_W'(src_r);

  assign status.emit_ok   = (CMP_W'(emitted_r) < limit_x) && (emitted_r != COUNT_MAX) &&
                            (CMP_W'(pos_r[POS_BITS-1:8]) <= src_x);
  assign status.more_next = (CMP_W'(emitted_inc) < limit_x) && (emitted_inc != COUNT_MAX) &&
                            (CMP_W'(pos_sat[POS_BITS-1:8]) <= src_x);
  assign status.out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channels_r <= 2'd1;
      wide_r     <= 1'b1;
      step_r     <= STEP_BITS'(256);
      limit_r    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CHANNELS: channels_r <= cfg_wdata[1:0];
        REG_WIDE:     wide_r     <= cfg_wdata[0];
        REG_STEP:     step_r     <= cfg_wdata[STEP_BITS-1:0];
        REG_LIMIT:    limit_r    <= cfg_wdata[LIMIT_BITS-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r     <= '0;
      emitted_r <= '0;
      pos_r     <= '0;
    end else begin
      if (cmd.emit) begin
        emitted_r <= emitted_inc;
        pos_r     <= pos_sat;
      end
      if (cmd.finish && src_r != COUNT_MAX) begin
        src_r <= src_r + 1'b1;
      end
    end
  end

  // Hold the widened frame for the whole run
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_r  <= first_w;
      second_r <= second_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_first_r  <= first_r;
      out_second_r <= second_r;
      out_last_r   <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_second_r, out_first_r};
  assign out_tlast  = out_last_r;

endmodule

>>> hdl/nearest_sample_rate_converter.sv
// Channel  Dir  Handshake          Payload
// in_      in   in_tvalid/tready   in_tdata: raw_first[15:0], raw_second[31:16]
// out_     out  out_tvalid/tready  out_tdata: sample_first, sample_second; out_tlast
// cfg_     in   cfg_wr_en          cfg_index, cfg_wdata
//
// A source frame is accepted in the idle state; the run state then produces its
// outputs (up to eight), or ends the run without output when it produces none.
// The run sequencer emits one output per cycle while the output register is free.
// Reset is synchronous, active low, and leaves the block ready at once.
// A stalled output holds the run in place until the output register frees.
module nearest_sample_rate_converter
  import nsrc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [2*SAMPLE_BITS-1:0] in_tdata,   // raw_first, raw_second
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [2*SAMPLE_BITS-1:0] out_tdata,  // sample_first, sample_second
  output logic                     out_tlast,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  nsrc_cmd_t    cmd;
  nsrc_status_t status;

  nsrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  nsrc_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> hdl/nsrc_checker.sv
module nsrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // Busy with a frame in the cycle after its transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken in back-to-back cycles");

  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("stalled output dropped");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

endmodule

bind nearest_sample_rate_converter nsrc_checker u_nsrc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

>>> bench/tb_nearest_sample_rate_converter.sv
module tb_nearest_sample_rate_converter;
  import nsrc_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 12;   // a frame with no output still occupies the block
  localparam int RUN_CAP       = 8;
  localparam int MAX_REPORTS   = 40;
  localparam int LIMIT_CYCLES  = 1_000_000;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] first;
    logic [SAMPLE_BITS-1:0] second;
    logic                   last;
  } pcm_frame_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [2*SAMPLE_BITS-1:0] in_tdata;   // raw_first [15:0], raw_second [31:16]
  logic                     out_tvalid;
  logic                     out_tready;
  logic [2*SAMPLE_BITS-1:0] out_tdata;  // sample_first [15:0], sample_second [31:16]
  logic                     out_tlast;
  logic                     cfg_wr_en;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  // Mirror of the converter settings and counters
  logic [1:0]            cur_channels;
  logic                  cur_wide;
  logic [STEP_BITS-1:0]  cur_step;
  logic [LIMIT_BITS-1:0] cur_cap;
  logic [COUNT_BITS-1:0] frames_in;
  logic [COUNT_BITS-1:0] frames_out;
  logic [POS_BITS-1:0]   out_pos;

  pcm_frame_t pending_frames[$];

  int  mismatches;
  int  frames_sent;
  int  results_predicted;
  int  results_checked;
  int  settings_used;
  int  sink_hold;
  bit  tx_gaps_on;
  bit  sink_gaps_on;

  nearest_sample_rate_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] to_pcm16(input logic [SAMPLE_BITS-1:0] raw);
    if (cur_wide) return raw;
    // unsigned byte to signed 16-bit: flip the sign bit, move to the top byte
    return {raw[7:0] ^ 8'h80, 8'h00};
  endfunction

  task automatic predict_frame(input logic [2*SAMPLE_BITS-1:0] raw);
    logic                   stereo;
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
    logic [POS_BITS:0]      pos_sum;
    pcm_frame_t             run [RUN_CAP];
    int                     n;
    stereo = (cur_channels == CHANNELS_STEREO);
    left   = to_pcm16(raw[SAMPLE_BITS-1:0]);
    right  = stereo ? to_pcm16(raw[2*SAMPLE_BITS-1:SAMPLE_BITS]) : '0;
    n = 0;
    while (n < RUN_CAP && frames_out < cur_cap && frames_out != '1 &&
           (out_pos >> 8) <= frames_in) begin
      run[n] = '{first: left, second: right, last: 1'b0};
      n++;
      frames_out++;
      pos_sum = {1'b0, out_pos} + cur_step;
      out_pos = pos_sum[POS_BITS] ? '1 : pos_sum[POS_BITS-1:0];
    end
    for (int k = 0; k < n; k++) begin
      run[k].last = (k == n - 1);
      pending_frames.push_back(run[k]);
    end
    results_predicted += n;
    if (frames_in != '1) frames_in++;
  endtask

  task automatic report_mismatch(input string what, input logic [32:0] got,
                                 input logic [32:0] want);
    if (mismatches < MAX_REPORTS)
      $display("mismatch on %s at %0t: got %h, want %h", what, $realtime, got, want);
    mismatches++;
  endtask

  // Called at a falling edge; returns at a falling edge with in_tvalid possibly still high
  task automatic send_frame(input logic [2*SAMPLE_BITS-1:0] raw);
    int gap;
    in_tdata  <= raw;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_frame(raw);
    frames_sent++;
    @(negedge clk);
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop the input and wait until the block has nothing left to deliver
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx,
                         input logic [CFG_DATA_BITS-1:0] word);
    cfg_index <= idx;
    cfg_wdata <= word;
    @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_BITS-1:0] chan_word,
                           input logic [CFG_DATA_BITS-1:0] wide_word,
                           input logic [CFG_DATA_BITS-1:0] step_word,
                           input logic [CFG_DATA_BITS-1:0] cap_word);
    settle();
    cfg_wr_en <= 1'b1;
    put_reg(REG_CHANNELS, chan_word);
    put_reg(REG_WIDE, wide_word);
    put_reg(REG_STEP, step_word);
    put_reg(REG_LIMIT, cap_word);
    cfg_wr_en <= 1'b0;
    cur_channels = chan_word[1:0];
    cur_wide     = wide_word[0];
    cur_step     = step_word[STEP_BITS-1:0];
    cur_cap      = cap_word[LIMIT_BITS-1:0];
    settings_used++;
  endtask

  always @(posedge clk) begin : score
    pcm_frame_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (pending_frames.size() == 0) begin
        report_mismatch("unexpected transfer", {out_tlast, out_tdata}, '0);
      end else begin
        want = pending_frames.pop_front();
        if (out_tdata[SAMPLE_BITS-1:0] !== want.first)
          report_mismatch("sample_first", out_tdata[SAMPLE_BITS-1:0], want.first);
        if (out_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] !== want.second)
          report_mismatch("sample_second", out_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS],
                          want.second);
        if (out_tlast !== want.last)
          report_mismatch("last_of_run", out_tlast, want.last);
      end
    end
  end

  // Receiver: random stalls, or one long hold-off when asked
  initial begin : sink
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_tready <= 1'b0;
        repeat (sink_hold) @(negedge clk);
        sink_hold = 0;
      end else begin
        stall = sink_gaps_on ? pick_gap() : 0;
        if (stall == 0) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
    end
  end

  // The output cap resets to zero, so nothing may come out yet
  task automatic test_reset_state();
    send_frame(32'h0000_0000);
    send_frame(32'hFFFF_FFFF);
  endtask

  task automatic test_sample_formats();
    configure(24'h000002, 24'h000001, 24'd256, 24'hFFFFFF);
    send_frame(32'h8000_7FFF);
    send_frame(32'h7FFF_8000);
    send_frame(32'h0001_FFFE);
    // unused channel code acts as mono; eight-bit source
    configure(24'hFFFFFF, 24'hFFFFFE, 24'd256, 24'hFFFFFF);
    send_frame(32'hFFFF_0000);
    send_frame(32'h0000_FF80);
    send_frame(32'h5A5A_A5FF);
    configure(24'h000002, 24'h000000, 24'd256, 24'hFFFFFF);
    send_frame(32'h00FF_FF00);
  endtask

  // Stop partway through a run once the cap is reached
  task automatic test_output_cap();
    configure(24'h000002, 24'h000001, 24'd64, frames_out + 24'd3);
    send_frame(32'h1234_5678);
    send_frame(32'h9ABC_DEF0);
  endtask

  task automatic test_step_extremes();
    // step field zero (junk above it): eight outputs from every frame
    configure(24'h000000, 24'h000001, 24'hABC800, 24'hFFFFFF);
    send_frame($urandom);
    configure(24'h000002, 24'h000001, 24'd32, 24'hFFFFFF);
    send_frame($urandom);
    send_frame($urandom);
    configure(24'h000002, 24'h000000, 24'h0007FF, 24'hFFFFFF);
    repeat (3) send_frame($urandom);
    configure(24'h000001, 24'h000001, 24'd1024, 24'hFFFFFF);
    repeat (2) send_frame($urandom);
  endtask

  // Hold the receiver off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    configure(24'h000002, 24'h000001, 24'd32, 24'hFFFFFF);
    sink_hold  = 300;
    tx_gaps_on = 1'b0;
    repeat (12) send_frame($urandom);
    tx_gaps_on = 1'b1;
    settle();
  endtask

  task automatic test_streaming();
    configure(24'h000002, 24'h000000, 24'd128, 24'hFFFFFF);
    sink_gaps_on = 1'b0;
    tx_gaps_on   = 1'b0;
    repeat (20) send_frame($urandom);
    settle();
    sink_gaps_on = 1'b1;
    tx_gaps_on   = 1'b1;
  endtask

  task automatic test_random_phases();
    int                       sent;
    int                       frames;
    int                       pick;
    logic [1:0]               code;
    logic [CFG_DATA_BITS-1:0] step_word;
    logic [CFG_DATA_BITS-1:0] cap_word;
    sent = 0;
    while (sent < 50) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)
        step_word = {13'($urandom), 11'($urandom_range(32, 1024))};
      else if (pick == 7)
        step_word = {13'($urandom), 11'($urandom_range(0, 31))};
      else
        step_word = {13'($urandom), 11'($urandom_range(1025, 2047))};
      pick = $urandom_range(0, 9);
      if (pick == 0)
        cap_word = frames_out + 24'($urandom_range(0, 40));
      else if (pick == 1)
        cap_word = '1;
      else
        cap_word = 24'($urandom);
      code = $urandom_range(0, 1) ? CHANNELS_STEREO : 2'($urandom);
      configure({22'($urandom), code}, 24'($urandom), step_word, cap_word);
      frames = $urandom_range(5, 20);
      repeat (frames) send_frame($urandom);
      sent += frames;
    end
  endtask

  initial begin : main
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_wr_en    = 1'b0;
    cfg_index    = REG_CHANNELS;
    cfg_wdata    = '0;
    tx_gaps_on   = 1'b1;
    sink_gaps_on = 1'b1;
    sink_hold    = 0;
    cur_channels = 2'd1;
    cur_wide     = 1'b1;
    cur_step     = 11'd256;
    cur_cap      = '0;
    frames_in    = '0;
    frames_out   = '0;
    out_pos      = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_sample_formats();
    test_output_cap();
    test_step_extremes();
    test_backpressure();
    test_streaming();
    test_random_phases();
    settle();

    $display("Resampled %0d source frames under %0d register settings (mono and stereo,",
             frames_sent, settings_used);
    $display("8 and 16 bit, steps 0 to 2047, output caps); %0d output frames checked.",
             results_checked);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(2 * HALF_PERIOD * LIMIT_CYCLES);
    $display("run timed out with %0d results outstanding", pending_frames.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
hdl/nsrc_pkg.sv
hdl/nsrc_ctrl.sv
hdl/nsrc_datapath.sv
hdl/nearest_sample_rate_converter.sv
hdl/nsrc_checker.sv
bench/tb_nearest_sample_rate_converter.sv
